>>> sv/sfe_pkg.sv
// shared types and constants for the stair led fade engine
// no dependencies; compiled before every other file

package sfe_pkg;

   localparam int MAX_LEDS_DEF = 64;   // default strip length
   localparam int CNT_W        = 7;    // count and zone register width
   localparam int IDX_W        = 6;    // led index field width
   localparam int LVL_W        = 8;    // brightness width
   localparam int TIME_W       = 32;   // timestamp width
   localparam int CSR_IDX_W    = 3;    // register index width
   localparam int CSR_DATA_W   = 8;    // register data width

   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_EMERG   = 2'd1,
      OP_REFRESH = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIP_LEN   = 3'd0,
      CSR_ON_LEVEL    = 3'd1,
      CSR_OFF_LEVEL   = 3'd2,
      CSR_UP_STEP     = 3'd3,
      CSR_DOWN_STEP   = 3'd4,
      CSR_BOTTOM_ZONE = 3'd5,
      CSR_TOP_ZONE    = 3'd6
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } fsm_state_type;

   // per-led state carried around the ring
   typedef struct packed {
      logic [LVL_W-1:0]  level;
      logic              request;
      logic [TIME_W-1:0] stamp;
   } led_cell_type;

   typedef struct packed {
      logic [LVL_W-1:0] on_level;
      logic [LVL_W-1:0] off_level;
      logic [LVL_W-1:0] up_step;
      logic [LVL_W-1:0] down_step;
   } fade_cfg_type;

   // per-cycle control for the head of the ring
   typedef struct packed {
      op_type            op;
      logic              set_hit;
      logic              lit;
      logic [TIME_W-1:0] event_time;
      logic              in_range;
      logic              force_up;
   } fade_ctrl_type;

endpackage

>>> sv/sfe_if.sv
// item channels of the stair led fade engine: request, response, register write
// depends on sfe_pkg

interface sfe_req_if;
   import sfe_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [IDX_W-1:0]    led_index;
   logic                lit;
   logic [TIME_W-1:0]   event_time;
   logic                emergency_which;

   modport source (output valid, op, led_index, lit, event_time, emergency_which,
                   input ready);
   modport sink (input valid, op, led_index, lit, event_time, emergency_which,
                 output ready);
endinterface

interface sfe_rsp_if;
   import sfe_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    out_index;
   logic [LVL_W-1:0]    out_level;
   logic                last;
   logic                frame_changed;
   logic                error;

   modport source (output valid, out_index, out_level, last, frame_changed, error,
                   input ready);
   modport sink (input valid, out_index, out_level, last, frame_changed, error,
                 output ready);
endinterface

interface sfe_csr_if;
   import sfe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sfe_cell.sv
// one ring cell: holds the state of one led and passes it to its neighbor
// depends on sfe_pkg

module sfe_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  sfe_pkg::led_cell_type d_in,
   output sfe_pkg::led_cell_type q_out
);
   import sfe_pkg::*;

   led_cell_type cell_ff;
   led_cell_type cell_in;

   assign cell_in = shift ? d_in : cell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign q_out = cell_ff;
endmodule

>>> sv/sfe_fade_unit.sv
// head-of-ring update: request write on a newer stamp, ramp up or down on refresh
// depends on sfe_pkg

module sfe_fade_unit (
   input  sfe_pkg::led_cell_type  head,
   input  sfe_pkg::fade_ctrl_type ctrl,
   input  sfe_pkg::fade_cfg_type  cfg,
   output sfe_pkg::led_cell_type  updated,
   output logic                   took_ramp
);
   import sfe_pkg::*;

   logic [LVL_W:0] up_sum;
   logic [LVL_W:0] floor_sum;

   assign up_sum    = {1'b0, head.level} + {1'b0, cfg.up_step};
   assign floor_sum = {1'b0, cfg.off_level} + {1'b0, cfg.down_step};

   always_comb begin
      updated   = head;
      took_ramp = 1'b0;
      case (ctrl.op)
         OP_SET: begin
            if (ctrl.set_hit && (head.stamp < ctrl.event_time)) begin
               updated.request = ctrl.lit;
               updated.stamp   = ctrl.event_time;
            end
         end
         OP_REFRESH: begin
            if (ctrl.in_range) begin
               if ((head.request && (head.level != cfg.on_level)) || ctrl.force_up) begin
                  // saturate at the ceiling, also pulls an over-bright led down to it
                  updated.level = (up_sum > {1'b0, cfg.on_level}) ? cfg.on_level
                                                                  : up_sum[LVL_W-1:0];
                  took_ramp = 1'b1;
               end else if (!head.request && (head.level != cfg.off_level)) begin
                  updated.level = ({1'b0, head.level} < floor_sum) ? cfg.off_level
                                  : head.level - cfg.down_step;
                  took_ramp = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end
endmodule

>>> sv/stair_led_fade_engine_unit.sv
// top level of the stair led fade engine: config registers, ring of led cells, sequencer
// depends on sfe_pkg, sfe_if, sfe_cell, sfe_fade_unit
//
//   channel   dir   handshake      moves
//   req_chan  in    valid/ready    one item: set request, emergency flag or refresh tick
//   rsp_chan  out   valid/ready    result items: one per item, one per led on refresh
//   csr_chan  in    valid/ready    register write, ready always high
//
// emergency items and set requests with a bad index answer in the next cycle
// a refresh tick or an in-range set request turns the ring of MAX_LEDS cells once,
//   one led reaching the head cell each cycle while no stalled response holds it
// a stalled response holds the ring in place; the next item waits for the turn to end
// reset clears every cell and the flags and loads the register defaults, no sweep

module stair_led_fade_engine_unit #(
   parameter int MAX_LEDS = sfe_pkg::MAX_LEDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sfe_req_if.sink     req_chan,
   sfe_rsp_if.source   rsp_chan,
   sfe_csr_if.sink     csr_chan
);
   import sfe_pkg::*;

   localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam logic [IW-1:0]    LAST_CNT = IW'(MAX_LEDS - 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LEDS);

   // configuration registers
   logic [CNT_W-1:0] strip_len_ff;
   logic [LVL_W-1:0] on_level_ff;
   logic [LVL_W-1:0] off_level_ff;
   logic [LVL_W-1:0] up_step_ff;
   logic [LVL_W-1:0] down_step_ff;
   logic [CNT_W-1:0] bottom_zone_ff;
   logic [CNT_W-1:0] top_zone_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_len_ff   <= CNT_W'(64);
         on_level_ff    <= LVL_W'(255);
         off_level_ff   <= '0;
         up_step_ff     <= LVL_W'(8);
         down_step_ff   <= LVL_W'(4);
         bottom_zone_ff <= '0;
         top_zone_ff    <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_STRIP_LEN:   strip_len_ff   <= csr_chan.data[CNT_W-1:0];
            CSR_ON_LEVEL:    on_level_ff    <= csr_chan.data;
            CSR_OFF_LEVEL:   off_level_ff   <= csr_chan.data;
            CSR_UP_STEP:     up_step_ff     <= csr_chan.data;
            CSR_DOWN_STEP:   down_step_ff   <= csr_chan.data;
            CSR_BOTTOM_ZONE: bottom_zone_ff <= csr_chan.data[CNT_W-1:0];
            CSR_TOP_ZONE:    top_zone_ff    <= csr_chan.data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // effective led count and start of the down zone
   logic [CNT_W-1:0] n_leds;
   logic [CNT_W-1:0] top_clamped;
   logic [CNT_W-1:0] top_start;

   assign n_leds      = (strip_len_ff > MAX_CNT) ? MAX_CNT : strip_len_ff;
   assign top_clamped = (top_zone_ff > n_leds) ? n_leds : top_zone_ff;
   assign top_start   = n_leds - top_clamped;

   // sequencer state and latched item
   fsm_state_type     state_ff, state_in;
   op_type            op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              lit_ff;
   logic [TIME_W-1:0] time_ff;
   logic [IW-1:0]     count_ff;
   logic              changed_ff;
   logic [1:0]        emerg_ff;    // bit0 up zone, bit1 down zone

   logic             req_fire;
   logic             out_free;
   logic             advance;
   logic             emit;
   logic [CNT_W-1:0] cnt_wide;
   logic             in_range;
   logic             is_final;
   logic             req_in_range;
   logic             req_walks;
   logic             req_immediate;

   assign req_fire     = req_chan.valid && req_chan.ready;
   assign out_free     = !rsp_chan.valid || rsp_chan.ready;
   assign cnt_wide     = CNT_W'(count_ff);
   assign in_range     = cnt_wide < n_leds;
   assign is_final     = cnt_wide == (n_leds - CNT_W'(1));
   assign req_in_range = CNT_W'(req_chan.led_index) < n_leds;
   assign req_walks    = ((req_chan.op == OP_SET) && req_in_range) ||
                         (req_chan.op == OP_REFRESH);
   assign req_immediate = (req_chan.op == OP_EMERG) ||
                          ((req_chan.op == OP_SET) && !req_in_range);

   // a refresh emits for every led in use; a set request answers at the end of the turn
   assign emit = ((op_ff == OP_REFRESH) && in_range) ||
                 ((op_ff == OP_SET) && (count_ff == LAST_CNT));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_walks) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (advance && (count_ff == LAST_CNT)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_chan.ready = 1'b0;
      advance        = 1'b0;
      case (state_ff)
         ST_IDLE: req_chan.ready = out_free;
         ST_WALK: advance = !emit || out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ring of cells, cell 0 is the head seen by the fade unit
   led_cell_type cell_q [MAX_LEDS];
   led_cell_type head_new;
   logic         took_ramp;
   fade_ctrl_type ctrl;
   fade_cfg_type  cfg;

   assign cfg.on_level  = on_level_ff;
   assign cfg.off_level = off_level_ff;
   assign cfg.up_step   = up_step_ff;
   assign cfg.down_step = down_step_ff;

   assign ctrl.op         = op_ff;
   assign ctrl.set_hit    = cnt_wide == CNT_W'(idx_ff);
   assign ctrl.lit        = lit_ff;
   assign ctrl.event_time = time_ff;
   assign ctrl.in_range   = in_range;
   assign ctrl.force_up   = (emerg_ff[0] && (cnt_wide < bottom_zone_ff)) ||
                            (emerg_ff[1] && (cnt_wide >= top_start));

   sfe_fade_unit u_fade (
      .head      (cell_q[0]),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .updated   (head_new),
      .took_ramp (took_ramp)
   );

   for (genvar k = 0; k < MAX_LEDS; k++) begin : g_ring
      led_cell_type d_next;
      if (k == MAX_LEDS - 1) begin : g_tail
         assign d_next = head_new;     // updated head re-enters at the tail
      end else begin : g_mid
         assign d_next = cell_q[k+1];
      end
      sfe_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (advance),
         .d_in  (d_next),
         .q_out (cell_q[k])
      );
   end

   // latched item, walk counter, change flag, emergency flags
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         changed_ff <= 1'b0;
         emerg_ff   <= '0;
      end else begin
         if (req_fire) begin
            count_ff   <= '0;
            changed_ff <= 1'b0;
            if (req_chan.op == OP_EMERG) begin
               emerg_ff[req_chan.emergency_which] <= req_chan.lit;
            end
         end else if (advance) begin
            count_ff   <= (count_ff == LAST_CNT) ? '0 : count_ff + IW'(1);
            changed_ff <= changed_ff || took_ramp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= op_type'(req_chan.op);
         idx_ff  <= req_chan.led_index;
         lit_ff  <= req_chan.lit;
         time_ff <= req_chan.event_time;
      end
   end

   // response register
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [LVL_W-1:0] rsp_level_ff;
   logic             rsp_last_ff;
   logic             rsp_changed_ff;
   logic             rsp_error_ff;

   logic walk_load;
   logic imm_load;

   assign walk_load = advance && emit;
   assign imm_load  = req_fire && req_immediate;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= walk_load || imm_load;
      end
   end

   always_ff @(posedge clock) begin
      if (imm_load) begin
         rsp_index_ff   <= (req_chan.op == OP_EMERG) ? '0 : req_chan.led_index;
         rsp_level_ff   <= '0;
         rsp_last_ff    <= 1'b1;
         rsp_changed_ff <= 1'b0;
         rsp_error_ff   <= (req_chan.op == OP_SET);
      end else if (walk_load) begin
         if (op_ff == OP_REFRESH) begin
            rsp_index_ff   <= IDX_W'(count_ff);
            rsp_level_ff   <= head_new.level;
            rsp_last_ff    <= is_final;
            rsp_changed_ff <= is_final && (changed_ff || took_ramp);
         end else begin
            // end of a set request turn
            rsp_index_ff   <= idx_ff;
            rsp_level_ff   <= '0;
            rsp_last_ff    <= 1'b1;
            rsp_changed_ff <= 1'b0;
         end
         rsp_error_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_index     = rsp_index_ff;
   assign rsp_chan.out_level     = rsp_level_ff;
   assign rsp_chan.last          = rsp_last_ff;
   assign rsp_chan.frame_changed = rsp_changed_ff;
   assign rsp_chan.error         = rsp_error_ff;

endmodule

>>> sv/sfe_checker.sv
// port-level checks of the stair led fade engine, bound to its top level
// depends on sfe_pkg and stair_led_fade_engine_unit

module sfe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [1:0]                req_op,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [sfe_pkg::IDX_W-1:0] rsp_out_index,
   input logic [sfe_pkg::LVL_W-1:0] rsp_out_level,
   input logic                      rsp_last,
   input logic                      rsp_frame_changed,
   input logic                      rsp_error
);
   import sfe_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_index) &&
         $stable(rsp_out_level) && $stable(rsp_last) &&
         $stable(rsp_frame_changed) && $stable(rsp_error)))
      else $error("response changed while stalled");

   // error and change flags only on the closing item
   a_flags_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error || rsp_frame_changed)) |-> rsp_last)
      else $error("flag set on a non-final result");

   // an emergency item answers in the next cycle
   a_emerg_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_EMERG)) |=> (rsp_valid && rsp_last &&
         !rsp_error && (rsp_out_index == '0) && (rsp_out_level == '0)))
      else $error("emergency item not answered");

   // the unused op code gives no result
   a_unused_op: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op != OP_SET) && (req_op != OP_EMERG) &&
         (req_op != OP_REFRESH)) |=> !rsp_valid)
      else $error("result for an unused op code");

endmodule

bind stair_led_fade_engine_unit sfe_checker u_sfe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_op            (req_chan.op),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_index     (rsp_chan.out_index),
   .rsp_out_level     (rsp_chan.out_level),
   .rsp_last          (rsp_chan.last),
   .rsp_frame_changed (rsp_chan.frame_changed),
   .rsp_error         (rsp_chan.error)
);
